// ===== design/am824pf_pkg.sv =====
package am824pf_pkg;

  // header field constants
  localparam logic [7:0]  FMT_AMDTP  = 8'h10;
  localparam logic [7:0]  FDF_NODATA = 8'hFF;
  localparam logic [15:0] SYT_NONE   = 16'hFFFF;

  // am824 event patterns
  localparam logic [31:0] EV_AUDIO_ZERO = 32'h4000_0000;
  localparam logic [31:0] EV_AUDIO_MAX  = 32'h407F_FFFF;
  localparam logic [31:0] EV_AUDIO_MIN  = 32'h4080_0001;
  localparam logic [31:0] EV_MIDI       = 32'h8000_0000;
  localparam logic [23:0] AUDIO_SCALE   = 24'h7F_FFFF;

  // full scale in q2.29
  localparam logic signed [31:0] Q_ONE     = 32'sh2000_0000;
  localparam logic signed [31:0] Q_NEG_ONE = -32'sh2000_0000;

  // input item kinds
  typedef enum logic [1:0] {
    KIND_DATA_HDR  = 2'd0,
    KIND_EMPTY_HDR = 2'd1,
    KIND_SAMPLE    = 2'd2
  } kind_e;

  // one output quadlet with its end-of-packet flag
  typedef struct packed {
    logic [31:0] quadlet;
    logic        last;
  } quad_entry_t;

  // up to two quadlets written into the output queue in one cycle
  typedef struct packed {
    logic [1:0]  cnt;
    quad_entry_t e0;
    quad_entry_t e1;
  } quad_push_t;

endpackage

// ===== design/am824_packet_framer_unit.sv =====
// flow: a request is taken into an input register, and its quadlets enter the output
// queue from there once the queue has room for two quadlets
// throughput: one sample request per cycle while the output queue has room; a header
// request gives two quadlets and the single output port moves one quadlet per cycle
// reset: configuration registers return to their defaults, block counter and event
// count clear, and the output queue empties
module am824_packet_framer_unit
  import am824pf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // request channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  kind_i,
  input  logic [15:0] syt_i,
  input  logic [31:0] sample_i,
  input  logic        is_midi_i,
  input  logic        silent_i,
  // quadlet channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] quadlet_o,
  output logic        last_of_packet_o
);

  localparam logic [2:0] REG_NODE_ID   = 3'd0;
  localparam logic [2:0] REG_CHAN_CNT  = 3'd1;
  localparam logic [2:0] REG_RATE_CODE = 3'd2;
  localparam logic [2:0] REG_CLIP_EN   = 3'd3;
  localparam logic [2:0] REG_NODATA    = 3'd4;

  // configuration registers
  logic [5:0]  node_id_q;
  logic [7:0]  channel_count_q;
  logic [2:0]  rate_code_q;
  logic        clip_enable_q;
  logic        nodata_payload_q;
  logic        cfg_wr;
  logic [2:0]  cfg_idx;

  // input register
  logic        s1_valid_q;
  logic [1:0]  s1_kind_q;
  logic [15:0] s1_syt_q;
  logic [31:0] s1_sample_q;
  logic        s1_midi_q;
  logic        s1_silent_q;
  logic        s1_fire;
  logic        in_fire;

  // packet state
  logic [7:0]  block_counter_q, block_counter_d;
  logic [12:0] events_left_q, events_left_d;
  logic        payload_empty_q, payload_empty_d;

  logic [5:0]  bpp;
  logic [7:0]  fdf;
  logic        payload;
  logic [31:0] q0, q1, ev;
  logic [12:0] hdr_events;
  logic [12:0] ev_left_dec;
  quad_push_t  push;
  quad_entry_t head;
  logic        room;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[4:2];

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_id_q        <= '0;
      channel_count_q  <= 8'd1;
      rate_code_q      <= 3'd2;
      clip_enable_q    <= 1'b0;
      nodata_payload_q <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_NODE_ID:   node_id_q        <= pwdata[5:0];
        REG_CHAN_CNT:  channel_count_q  <= pwdata[7:0];
        REG_RATE_CODE: rate_code_q      <= pwdata[2:0];
        REG_CLIP_EN:   clip_enable_q    <= pwdata[0];
        REG_NODATA:    nodata_payload_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    unique case (cfg_idx)
      REG_NODE_ID:   prdata = {26'd0, node_id_q};
      REG_CHAN_CNT:  prdata = {24'd0, channel_count_q};
      REG_RATE_CODE: prdata = {29'd0, rate_code_q};
      REG_CLIP_EN:   prdata = {31'd0, clip_enable_q};
      REG_NODATA:    prdata = {31'd0, nodata_payload_q};
      default:       prdata = '0;
    endcase
  end

  // input register handshake
  assign s1_fire    = s1_valid_q && room;
  assign in_ready_o = !s1_valid_q || s1_fire;
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_kind_q   <= kind_i;
      s1_syt_q    <= syt_i;
      s1_sample_q <= sample_i;
      s1_midi_q   <= is_midi_i;
      s1_silent_q <= silent_i;
    end
  end

  // blocks per packet from the rate code
  always_comb begin
    case (rate_code_q) inside
      3'd0, 3'd1, 3'd2: bpp = 6'd8;
      3'd3, 3'd4:       bpp = 6'd16;
      3'd5, 3'd6:       bpp = 6'd32;
      default:          bpp = 6'd0;
    endcase
  end

  am824pf_event_enc u_enc (
    .sample_i  (s1_sample_q),
    .is_midi_i (s1_midi_q),
    .zero_i    (payload_empty_q || s1_silent_q),
    .clip_en_i (clip_enable_q),
    .event_o   (ev)
  );

  // header quadlets, packet state and queue request
  always_comb begin
    payload     = (s1_kind_q == KIND_DATA_HDR) || nodata_payload_q;
    fdf         = (s1_kind_q == KIND_DATA_HDR) ?
                  ((rate_code_q == 3'd7) ? 8'd0 : {5'd0, rate_code_q}) : FDF_NODATA;
    hdr_events  = {7'd0, bpp} * {5'd0, channel_count_q};
    ev_left_dec = events_left_q - 13'd1;
    q0 = {2'b00, node_id_q, channel_count_q, 8'd0, block_counter_q};
    q1 = {8'h80 | FMT_AMDTP, fdf,
          (s1_kind_q == KIND_DATA_HDR) ? s1_syt_q : SYT_NONE};

    block_counter_d = block_counter_q;
    events_left_d   = events_left_q;
    payload_empty_d = payload_empty_q;
    push            = '0;

    if (s1_fire) begin
      case (s1_kind_q)
        KIND_DATA_HDR, KIND_EMPTY_HDR: begin
          events_left_d   = payload ? hdr_events : 13'd0;
          if (payload) begin
            block_counter_d = block_counter_q + {2'b00, bpp};
          end
          payload_empty_d = (s1_kind_q == KIND_EMPTY_HDR) && payload;
          push.cnt        = 2'd2;
          push.e0         = '{quadlet: q0, last: 1'b0};
          push.e1         = '{quadlet: q1, last: (events_left_d == 13'd0)};
        end
        KIND_SAMPLE: begin
          if (events_left_q != 13'd0) begin
            events_left_d = ev_left_dec;
            push.cnt      = 2'd1;
            push.e0       = '{quadlet: ev, last: (ev_left_dec == 13'd0)};
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_counter_q <= '0;
      events_left_q   <= '0;
      payload_empty_q <= 1'b0;
    end else begin
      block_counter_q <= block_counter_d;
      events_left_q   <= events_left_d;
      payload_empty_q <= payload_empty_d;
    end
  end

  // output queue
  am824pf_out_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (head)
  );

  assign quadlet_o        = head.quadlet;
  assign last_of_packet_o = head.last;

endmodule

// ===== design/am824pf_event_enc.sv =====
module am824pf_event_enc
  import am824pf_pkg::*;
(
  input  logic [31:0] sample_i,
  input  logic        is_midi_i,
  input  logic        zero_i,
  input  logic        clip_en_i,
  output logic [31:0] event_o
);

  logic signed [31:0] s;
  logic signed [55:0] prod;
  logic signed [55:0] adj;
  logic [23:0]        q24;

  // scale by 2^23-1, then divide by 2^29 rounding toward zero
  always_comb begin
    s    = $signed(sample_i);
    prod = s * $signed({1'b0, AUDIO_SCALE});
    adj  = prod + (prod[55] ? 56'sh0000_0000_1FFF_FFFF : 56'sh0);
    q24  = adj[52:29];
  end

  // pick the event pattern
  always_comb begin
    if (is_midi_i) begin
      event_o = EV_MIDI;
    end else if (zero_i) begin
      event_o = EV_AUDIO_ZERO;
    end else if (clip_en_i && (s > Q_ONE)) begin
      event_o = EV_AUDIO_MAX;
    end else if (clip_en_i && (s < Q_NEG_ONE)) begin
      event_o = EV_AUDIO_MIN;
    end else begin
      event_o = EV_AUDIO_ZERO | {8'h00, q24};
    end
  end

endmodule

// ===== design/am824pf_out_fifo.sv =====
module am824pf_out_fifo
  import am824pf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  quad_push_t  push_i,
  output logic        room_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output quad_entry_t out_o
);

  quad_entry_t mem_q [4];
  logic [1:0]  wr_ptr_q, wr_ptr_d;
  logic [1:0]  rd_ptr_q, rd_ptr_d;
  logic [2:0]  count_q, count_d;
  logic        pop;

  assign out_valid_o = (count_q != 3'd0);
  assign out_o       = mem_q[rd_ptr_q];
  assign pop         = out_valid_o && out_ready_i;
  // room for a full two-quadlet request
  assign room_o      = (count_q <= 3'd2);

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = wr_ptr_q + push_i.cnt;
    rd_ptr_d = rd_ptr_q + {1'b0, pop};
    count_d  = count_q + {1'b0, push_i.cnt} - {2'b00, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // storage, first entry then second
  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.e0;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wr_ptr_q + 2'd1] <= push_i.e1;
    end
  end

endmodule
